### hdl/nearest_downscale_rgb565_to_ycbcr_defines.svh
// Assertion helpers used by the checker file.
`ifndef NEAREST_DOWNSCALE_RGB565_TO_YCBCR_DEFINES_SVH
`define NEAREST_DOWNSCALE_RGB565_TO_YCBCR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define NDSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NDSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ndsc_pkg.sv
package ndsc_pkg;

   localparam int MAX_DIMENSION = 2048;
   localparam int CNT_W         = $clog2(MAX_DIMENSION);
   localparam int DIM_W         = CNT_W + 1;
   localparam int ACC_W         = 2 * CNT_W;

   localparam int CFG_W     = 12;
   localparam int PIX_W     = 16;
   localparam int CHAN_W    = 8;
   localparam int SUM_W     = 17;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 2'd3;

   localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 12'd640;
   localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 12'd480;
   localparam logic [CFG_W-1:0] RST_DST_WIDTH  = 12'd110;
   localparam logic [CFG_W-1:0] RST_DST_HEIGHT = 12'd110;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // BT.601 coefficients in Q8
   localparam int COEF_Y_R    = 77;
   localparam int COEF_Y_G    = 150;
   localparam int COEF_Y_B    = 29;
   localparam int COEF_HALF   = 128;
   localparam int COEF_CB_R   = 43;
   localparam int COEF_CB_G   = 85;
   localparam int COEF_CR_G   = 107;
   localparam int COEF_CR_B   = 21;
   localparam int CHROMA_BIAS = 32768;

   typedef struct packed {
      logic [DIM_W-1:0] src_width;
      logic [DIM_W-1:0] src_height;
      logic [DIM_W-1:0] dst_width;
      logic [DIM_W-1:0] dst_height;
   } sizes_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_rgb;
      logic             end_of_line;
      logic             end_of_frame;
   } item_type;

   // zero reads as one, anything above the maximum saturates
   function automatic logic [DIM_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > 32'(MAX_DIMENSION)) begin
         r = DIM_W'(MAX_DIMENSION);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

endpackage

### hdl/ndsc_front.sv
module ndsc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  ndsc_pkg::sizes_type             sizes,
   input  logic                            accept,
   input  logic [ndsc_pkg::PIX_W-1:0]      pixel_rgb,
   input  logic                            frame_start,
   output logic                            push,
   output ndsc_pkg::item_type              item
);
   import ndsc_pkg::*;

   logic [CNT_W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [CNT_W-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [ACC_W-1:0] col_tgt_ff, col_tgt_in, col_src_ff, col_src_in;
   logic [ACC_W-1:0] row_tgt_ff, row_tgt_in, row_src_ff, row_src_in;

   logic [CNT_W-1:0] src_col, src_row, out_col, out_row;
   logic [ACC_W-1:0] col_tgt, col_src, row_tgt, row_src;
   logic [ACC_W:0]   col_lim, row_lim;
   logic             col_hit, row_hit, eol, eof, line_end, frame_end, row_more;

   // frame start clears the state before this pixel is judged
   assign src_col = frame_start ? '0 : src_col_ff;
   assign src_row = frame_start ? '0 : src_row_ff;
   assign out_col = frame_start ? '0 : out_col_ff;
   assign out_row = frame_start ? '0 : out_row_ff;
   assign col_tgt = frame_start ? '0 : col_tgt_ff;
   assign col_src = frame_start ? '0 : col_src_ff;
   assign row_tgt = frame_start ? '0 : row_tgt_ff;
   assign row_src = frame_start ? '0 : row_src_ff;

   assign col_lim = {1'b0, col_src} + (ACC_W+1)'(sizes.dst_width);
   assign row_lim = {1'b0, row_src} + (ACC_W+1)'(sizes.dst_height);
   assign col_hit = (col_src <= col_tgt) && ({1'b0, col_tgt} < col_lim);
   assign row_hit = (row_src <= row_tgt) && ({1'b0, row_tgt} < row_lim);

   assign eol       = DIM_W'(out_col) >= (sizes.dst_width - DIM_W'(1));
   assign eof       = eol && (DIM_W'(out_row) >= (sizes.dst_height - DIM_W'(1)));
   assign line_end  = DIM_W'(src_col) >= (sizes.src_width - DIM_W'(1));
   assign frame_end = DIM_W'(src_row) >= (sizes.src_height - DIM_W'(1));
   assign row_more  = DIM_W'(out_row) < (sizes.dst_height - DIM_W'(1));

   always_comb begin
      src_col_in = src_col;
      src_row_in = src_row;
      out_col_in = out_col;
      out_row_in = out_row;
      col_tgt_in = col_tgt;
      col_src_in = col_src;
      row_tgt_in = row_tgt;
      row_src_in = row_src;
      if (row_hit && col_hit && !eol) begin
         out_col_in = out_col + CNT_W'(1);
         col_tgt_in = col_tgt + ACC_W'(sizes.src_width);
      end
      if (line_end) begin
         src_col_in = '0;
         col_src_in = '0;
         out_col_in = '0;
         col_tgt_in = '0;
         if (frame_end) begin
            src_row_in = '0;
            out_row_in = '0;
            row_tgt_in = '0;
            row_src_in = '0;
         end else begin
            if (row_hit && row_more) begin
               out_row_in = out_row + CNT_W'(1);
               row_tgt_in = row_tgt + ACC_W'(sizes.src_height);
            end
            src_row_in = src_row + CNT_W'(1);
            row_src_in = row_src + ACC_W'(sizes.dst_height);
         end
      end else begin
         src_col_in = src_col + CNT_W'(1);
         col_src_in = col_src + ACC_W'(sizes.dst_width);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         col_tgt_ff <= '0;
         col_src_ff <= '0;
         row_tgt_ff <= '0;
         row_src_ff <= '0;
      end else if (accept) begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         col_tgt_ff <= col_tgt_in;
         col_src_ff <= col_src_in;
         row_tgt_ff <= row_tgt_in;
         row_src_ff <= row_src_in;
      end
   end

   assign push              = accept && row_hit && col_hit;
   assign item.pixel_rgb    = pixel_rgb;
   assign item.end_of_line  = eol;
   assign item.end_of_frame = eof;

endmodule

### hdl/ndsc_queue.sv
module ndsc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ndsc_pkg::item_type push_item,
   output logic               ready,
   input  logic               pop,
   output ndsc_pkg::item_type head_item,
   output logic               head_valid
);
   import ndsc_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign ready      = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/ndsc_back.sv
module ndsc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  ndsc_pkg::item_type             head_item,
   input  logic                           head_valid,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [3*ndsc_pkg::CHAN_W-1:0]  rsp_tdata,
   output logic                           rsp_tlast,
   output logic                           rsp_tuser
);
   import ndsc_pkg::*;

   logic                  valid_ff, valid_in;
   logic [3*CHAN_W-1:0]   data_ff;
   logic                  eol_ff, eof_ff;
   logic [CHAN_W-1:0]     r8, g8, b8;
   logic [SUM_W-1:0]      y_sum, cb_sum, cr_sum;
   logic                  out_free;

   assign r8 = widen5(head_item.pixel_rgb[15:11]);
   assign g8 = widen6(head_item.pixel_rgb[10:5]);
   assign b8 = widen5(head_item.pixel_rgb[4:0]);

   // chroma sums stay non-negative, so wrapping intermediates are harmless
   assign y_sum  = SUM_W'(COEF_Y_R) * SUM_W'(r8) + SUM_W'(COEF_Y_G) * SUM_W'(g8)
                 + SUM_W'(COEF_Y_B) * SUM_W'(b8);
   assign cb_sum = SUM_W'(COEF_HALF) * SUM_W'(b8) + SUM_W'(CHROMA_BIAS)
                 - SUM_W'(COEF_CB_R) * SUM_W'(r8) - SUM_W'(COEF_CB_G) * SUM_W'(g8);
   assign cr_sum = SUM_W'(COEF_HALF) * SUM_W'(r8) + SUM_W'(CHROMA_BIAS)
                 - SUM_W'(COEF_CR_G) * SUM_W'(g8) - SUM_W'(COEF_CR_B) * SUM_W'(b8);

   assign out_free = !valid_ff || rsp_tready;
   assign pop      = head_valid && out_free;

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= {cr_sum[15:8], cb_sum[15:8], y_sum[15:8]};
         eol_ff  <= head_item.end_of_line;
         eof_ff  <= head_item.end_of_frame;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = eof_ff;
   assign rsp_tuser  = eol_ff;

endmodule

### hdl/nearest_downscale_rgb565_to_ycbcr.sv
// Channel   Direction  Payload (low bit first)                        Marks
// req_*     in         tdata: pixel_rgb[15:0]; tuser: frame_start    tvalid/tready
// rsp_*     out        tdata: luma, chroma_blue, chroma_red          tlast: end_of_frame,
//                                                                   tuser: end_of_line
// csr_*     in         wdata: size register, index 0..3              wr_en, no wait
//
// Takes one pixel per clock while the queue is not full. The front selects pixels
// with one accumulator window compare per axis; while its output register is free,
// the back converts one pixel per clock in one multiply stage. An accepted pixel is
// written into the queue, then converted from its head into the rsp output register.
// Reset clears counters, queue and output register and loads default sizes.
// With rsp_tready low the output register holds one result and the four-entry
// queue fills behind it, then req_tready drops.
module nearest_downscale_rgb565_to_ycbcr (
   input  logic                              clock,
   input  logic                              reset,
   // pixel_rgb[15:0]
   input  logic [ndsc_pkg::PIX_W-1:0]        req_tdata,
   // frame_start
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // luma[7:0], chroma_blue[15:8], chroma_red[23:16]
   output logic [3*ndsc_pkg::CHAN_W-1:0]     rsp_tdata,
   // end_of_line
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wr_en,
   input  logic [ndsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ndsc_pkg::CFG_W-1:0]        csr_wdata
);
   import ndsc_pkg::*;

   // Sizes are held already clamped to 1..MAX_DIMENSION.
   logic [DIM_W-1:0] src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   sizes_type        sizes;
   logic             accept, push, pop, q_ready, head_valid;
   item_type         push_item, head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= clamp_size(RST_SRC_WIDTH);
         src_height_ff <= clamp_size(RST_SRC_HEIGHT);
         dst_width_ff  <= clamp_size(RST_DST_WIDTH);
         dst_height_ff <= clamp_size(RST_DST_HEIGHT);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= clamp_size(csr_wdata);
            CSR_SRC_HEIGHT: src_height_ff <= clamp_size(csr_wdata);
            CSR_DST_WIDTH:  dst_width_ff  <= clamp_size(csr_wdata);
            CSR_DST_HEIGHT: dst_height_ff <= clamp_size(csr_wdata);
         endcase
      end
   end

   // Downscale only: clamp the output size to the source size.
   assign sizes.src_width  = src_width_ff;
   assign sizes.src_height = src_height_ff;
   assign sizes.dst_width  = (dst_width_ff > src_width_ff) ? src_width_ff : dst_width_ff;
   assign sizes.dst_height = (dst_height_ff > src_height_ff) ? src_height_ff : dst_height_ff;

   // Hold off the source only when the queue is full.
   assign req_tready = q_ready;
   assign accept     = req_tvalid && q_ready;

   ndsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .sizes       (sizes),
      .accept      (accept),
      .pixel_rgb   (req_tdata),
      .frame_start (req_tuser),
      .push        (push),
      .item        (push_item)
   );

   ndsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .ready      (q_ready),
      .pop        (pop),
      .head_item  (head_item),
      .head_valid (head_valid)
   );

   ndsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### hdl/ndsc_checker.sv
`include "nearest_downscale_rgb565_to_ycbcr_defines.svh"

module ndsc_checker (
   input logic        clock,
   input logic        reset,
   input logic [15:0] req_tdata,
   input logic        req_tuser,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        csr_wr_en,
   input logic [1:0]  csr_index,
   input logic [11:0] csr_wdata
);

   `NDSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser),
      "stalled transaction changed")
   `NDSC_ASSERT_SAME(a_eof_on_eol, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser,
      "frame end without line end")
   `NDSC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid,
      "result valid right after reset")
   `NDSC_ASSERT_SAME(a_full_only_stalled, clock, reset, !req_tready, rsp_tvalid,
      "input held off while output idle")

endmodule

bind nearest_downscale_rgb565_to_ycbcr ndsc_checker u_checker (.*);

### test/tb_nearest_downscale_rgb565_to_ycbcr.sv
module tb_nearest_downscale_rgb565_to_ycbcr;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with no transaction, no CSR write and no reset before the run gives up.
   localparam int QUIET_LIMIT   = 2000;
   // Cycles to let pass once nothing is expected: covers the queue and the
   // output register plus a pixel that selects nothing.
   localparam int SETTLE_CYCLES = 8;
   // Minimum number of random source pixels to send after the directed part.
   localparam int RANDOM_PIXELS = 410;

   typedef struct {
      logic [ndsc_pkg::PIX_W-1:0] pix;
      logic                       frame_start;
   } src_pixel_type;

   typedef struct {
      logic [ndsc_pkg::CHAN_W-1:0] luma;
      logic [ndsc_pkg::CHAN_W-1:0] cb;
      logic [ndsc_pkg::CHAN_W-1:0] cr;
      logic                        eol;
      logic                        eof;
   } ycbcr_px_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [ndsc_pkg::PIX_W-1:0]     req_tdata  = '0;
   logic                           req_tuser  = 1'b0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [3*ndsc_pkg::CHAN_W-1:0]  rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           csr_wr_en  = 1'b0;
   logic [ndsc_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [ndsc_pkg::CFG_W-1:0]     csr_wdata  = '0;

   // Pixels waiting for the driver, and converted pixels due on rsp.
   src_pixel_type pending_pixels[$];
   ycbcr_px_type  ycbcr_due[$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned mismatches    = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned random_sent   = 0;

   // Scaler's size registers as the testbench last wrote them.
   logic [ndsc_pkg::CFG_W-1:0] size_src_w, size_src_h, size_dst_w, size_dst_h;

   // Scan state of the scaler: source and output counters plus the four
   // accumulators that stand in for the multiply by the size ratio.
   logic [10:0] src_col, src_row, out_col, out_row;
   logic [21:0] col_dst_acc, col_src_acc, row_dst_acc, row_src_acc;

   nearest_downscale_rgb565_to_ycbcr dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Zero reads as one, anything past the maximum saturates.
   function automatic int unsigned limit_dim(input logic [ndsc_pkg::CFG_W-1:0] v);
      if (v == '0) return 1;
      if (32'(v) > ndsc_pkg::MAX_DIMENSION) return ndsc_pkg::MAX_DIMENSION;
      return 32'(v);
   endfunction

   function automatic void clear_scan();
      src_col     = '0;
      src_row     = '0;
      out_col     = '0;
      out_row     = '0;
      col_dst_acc = '0;
      col_src_acc = '0;
      row_dst_acc = '0;
      row_src_acc = '0;
   endfunction

   // Advance the scan by one source pixel; queue the converted pixel if the
   // pixel lands on an output sample.
   function automatic void scale_pixel(input logic [ndsc_pkg::PIX_W-1:0] pix,
                                       input logic frame_start);
      int unsigned  sw, sh, dw, dh, y, cb, cr;
      logic         row_hit, col_hit;
      logic [7:0]   r, g, b;
      ycbcr_px_type px;
      sw = limit_dim(size_src_w);
      sh = limit_dim(size_src_h);
      dw = limit_dim(size_dst_w);
      dh = limit_dim(size_dst_h);
      // downscale only: clamp the destination to the source
      if (dw > sw) dw = sw;
      if (dh > sh) dh = sh;
      if (frame_start) clear_scan();

      // hit when src*dst <= out*src < src*dst + dst, i.e. src == floor(out*src/dst)
      row_hit = 32'(row_src_acc) <= 32'(row_dst_acc) &&
                32'(row_dst_acc) < 32'(row_src_acc) + dh;
      col_hit = 32'(col_src_acc) <= 32'(col_dst_acc) &&
                32'(col_dst_acc) < 32'(col_src_acc) + dw;

      if (row_hit && col_hit) begin
         // widen 5/6-bit components by repeating their top bits
         r = {pix[15:11], pix[15:13]};
         g = {pix[10:5], pix[10:9]};
         b = {pix[4:0], pix[4:2]};
         y  = (77 * r + 150 * g + 29 * b) >> 8;
         cb = (128 * b + 32768 - 43 * r - 85 * g) >> 8;
         cr = (128 * r + 32768 - 107 * g - 21 * b) >> 8;
         px.luma = 8'(y);
         px.cb   = 8'(cb);
         px.cr   = 8'(cr);
         px.eol  = 32'(out_col) >= dw - 1;
         px.eof  = px.eol && 32'(out_row) >= dh - 1;
         ycbcr_due.push_back(px);
         // hold the output column on its last sample
         if (!px.eol) begin
            out_col     = out_col + 11'd1;
            col_dst_acc = col_dst_acc + 22'(sw);
         end
      end

      if (32'(src_col) >= sw - 1) begin
         src_col     = '0;
         col_src_acc = '0;
         out_col     = '0;
         col_dst_acc = '0;
         if (32'(src_row) >= sh - 1) begin
            clear_scan();
         end else begin
            if (row_hit && 32'(out_row) < dh - 1) begin
               out_row     = out_row + 11'd1;
               row_dst_acc = row_dst_acc + 22'(sh);
            end
            src_row     = src_row + 11'd1;
            row_src_acc = row_src_acc + 22'(dh);
         end
      end else begin
         src_col     = src_col + 11'd1;
         col_src_acc = col_src_acc + 22'(dw);
      end
   endfunction

   // Driver: predict on every accepted pixel, then offer the next one or idle.
   always @(posedge clock) begin : drive_pixels
      src_pixel_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) scale_pixel(req_tdata, req_tuser);
         if (!req_tvalid || req_tready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_pixels.pop_front();
               req_tdata  <= nxt.pix;
               req_tuser  <= nxt.frame_start;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each converted pixel with the oldest one due.
   always @(posedge clock) begin : check_pixels
      ycbcr_px_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.luma = rsp_tdata[7:0];
            got.cb   = rsp_tdata[15:8];
            got.cr   = rsp_tdata[23:16];
            got.eol  = rsp_tuser;
            got.eof  = rsp_tlast;
            if (ycbcr_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected pixel y=%0d cb=%0d cr=%0d eol=%0b eof=%0b",
                        $time, got.luma, got.cb, got.cr, got.eol, got.eof);
            end else begin
               want = ycbcr_due.pop_front();
               if (got.luma !== want.luma || got.cb !== want.cb || got.cr !== want.cr ||
                   got.eol !== want.eol || got.eof !== want.eof) begin
                  mismatches++;
                  $display("%0t: expected y=%0d cb=%0d cr=%0d eol=%0b eof=%0b", $time,
                           want.luma, want.cb, want.cr, want.eol, want.eof);
                  $display("%0t:   actual y=%0d cb=%0d cr=%0d eol=%0b eof=%0b", $time,
                           got.luma, got.cb, got.cr, got.eol, got.eof);
               end
            end
         end
         rsp_tready <= $urandom_range(99) >= rsp_stall_pct;
      end
   end

   // Watchdog: count cycles in which nothing moves.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Wait until the scaler is drained, then give pixels that select nothing
   // time to leave the pipeline.
   task automatic settle();
      while (pending_pixels.size() != 0 || req_tvalid || ycbcr_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(input logic [ndsc_pkg::CSR_IDX_W-1:0] idx,
                             input logic [ndsc_pkg::CFG_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         ndsc_pkg::CSR_SRC_WIDTH:  size_src_w = val;
         ndsc_pkg::CSR_SRC_HEIGHT: size_src_h = val;
         ndsc_pkg::CSR_DST_WIDTH:  size_dst_w = val;
         default:                  size_dst_h = val;
      endcase
   endtask

   // Drain, load all four sizes, pick the idle pattern and return at a
   // falling edge, ready to queue pixels.
   task automatic begin_phase(input logic [ndsc_pkg::CFG_W-1:0] sw, sh, dw, dh,
                              input int mode);
      settle();
      write_size(ndsc_pkg::CSR_SRC_WIDTH, sw);
      write_size(ndsc_pkg::CSR_SRC_HEIGHT, sh);
      write_size(ndsc_pkg::CSR_DST_WIDTH, dw);
      write_size(ndsc_pkg::CSR_DST_HEIGHT, dh);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 58; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 58; end
         default: begin send_idle_pct = 31; rsp_stall_pct = 31; end
      endcase
      @(negedge clock);
   endtask

   task automatic push_pixel(input logic [ndsc_pkg::PIX_W-1:0] pix, input logic fs);
      src_pixel_type p;
      p.pix         = pix;
      p.frame_start = fs;
      pending_pixels.push_back(p);
   endtask

   // One random phase: pick sizes (mostly small, now and then extreme),
   // then a run of pixels that mostly follows whole frames. Some phases
   // carry on from the previous scan state to exercise a size change
   // mid-frame; a stray frame_start now and then restarts the scan.
   task automatic run_random_phase(input int mode);
      logic [ndsc_pkg::CFG_W-1:0] sw, sh, dw, dh;
      int unsigned pick, frame_len, n;
      logic fresh, fs;
      pick = $urandom_range(9);
      if (pick == 0) begin
         // wide: full or oversize source width
         sw = $urandom_range(1) ? 12'd2048 : 12'hFFF;
         sh = 12'($urandom_range(0, 3));
         dw = $urandom_range(1) ? 12'hFFF : 12'($urandom_range(1, 40));
         dh = 12'($urandom_range(0, 3));
      end else if (pick == 1) begin
         // tall and narrow: rows advance every one or two pixels
         sw = 12'($urandom_range(0, 2));
         sh = $urandom_range(1) ? 12'd2048 : 12'hFFF;
         dw = 12'($urandom_range(0, 3));
         dh = $urandom_range(1) ? 12'd2048 : 12'($urandom_range(1, 300));
      end else begin
         sw = 12'($urandom_range(1, 12));
         sh = 12'($urandom_range(1, 8));
         dw = 12'($urandom_range(1, 32'(sw) + 3));
         dh = 12'($urandom_range(1, 32'(sh) + 2));
      end
      begin_phase(sw, sh, dw, dh, mode);

      frame_len = limit_dim(sw) * limit_dim(sh);
      n         = $urandom_range(25, 55);
      fresh     = $urandom_range(3) != 0;
      for (int unsigned i = 0; i < n; i++) begin
         fs = 1'b0;
         if (i % frame_len == 0) fs = (i == 0) ? fresh : 1'($urandom_range(1));
         if ($urandom_range(29) == 0) fs = 1'b1;
         push_pixel(16'($urandom), fs);
      end
      random_sent += n;
   endtask

   initial begin : stimulus
      logic [ndsc_pkg::PIX_W-1:0] hues [0:12];
      int unsigned phase_no;

      size_src_w = ndsc_pkg::RST_SRC_WIDTH;
      size_src_h = ndsc_pkg::RST_SRC_HEIGHT;
      size_dst_w = ndsc_pkg::RST_DST_WIDTH;
      size_dst_h = ndsc_pkg::RST_DST_HEIGHT;
      clear_scan();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default sizes straight out of reset: 640x480 down to 110x110.
      push_pixel(16'h0000, 1'b1);
      push_pixel(16'hFFFF, 1'b0);
      push_pixel(16'h8410, 1'b0);

      // 4x3 kept at full size: every pixel converts. Color extremes first;
      // the thirteenth pixel wraps into a new frame without frame_start.
      hues = '{16'hFFFF, 16'h0000, 16'hF800, 16'h07E0, 16'h001F, 16'hFFE0, 16'hF81F,
               16'h07FF, 16'h0821, 16'h8410, 16'h7BEF, 16'hAAAA, 16'h5555};
      begin_phase(12'd4, 12'd3, 12'd4, 12'd3, 0);
      for (int i = 0; i < 13; i++) push_pixel(hues[i], i == 0);

      // All sizes zero read as 1x1: each pixel ends its line and its frame.
      begin_phase(12'd0, 12'd0, 12'd0, 12'd0, 0);
      push_pixel(16'h1234, 1'b0);
      push_pixel(16'hFEDC, 1'b0);
      push_pixel(16'h0000, 1'b1);

      // Destination above source (and above the maximum) clamps to 3x2.
      begin_phase(12'd3, 12'd2, 12'hFFF, 12'd5, 0);
      push_pixel(16'hF800, 1'b1);
      for (int i = 0; i < 5; i++) push_pixel(16'($urandom), 1'b0);

      // Random phases, cycling through the idle patterns.
      phase_no = 0;
      while (random_sent < RANDOM_PIXELS) begin
         run_random_phase(phase_no % 4);
         phase_no++;
      end

      settle();
      if (mismatches == 0 && ycbcr_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (ycbcr_due.size() != 0)
            $display("%0t: %0d pixels never arrived", $time, ycbcr_due.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/ndsc_pkg.sv
hdl/ndsc_front.sv
hdl/ndsc_queue.sv
hdl/ndsc_back.sv
hdl/nearest_downscale_rgb565_to_ycbcr.sv
hdl/ndsc_checker.sv
test/tb_nearest_downscale_rgb565_to_ycbcr.sv
